>>> sv/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg: shared types and constants for the MIDI clock follower
// Event codes, state widths, watchdog and tempo constants, result struct.
// ----------------------------------------------------------------------------
package mcf_pkg;

    localparam int TIMEOUT_MS       = 250;
    localparam int TASK_INTERVAL_US = 1000;
    localparam int TICKS_PER_BEAT   = 24;

    localparam int FUNC_WIDTH = 3;
    localparam int SPOS_WIDTH = 14;
    localparam int US_WIDTH   = 22;
    localparam int DIV_WIDTH  = 2;
    localparam int POS_WIDTH  = 5;
    localparam int WDOG_WIDTH = 8;
    localparam int LEAD_WIDTH = 23;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [WDOG_WIDTH-1:0] WDOG_RELOAD  = WDOG_WIDTH'(TIMEOUT_MS);
    localparam logic [POS_WIDTH-1:0]  POS_LAST     = POS_WIDTH'(TICKS_PER_BEAT - 1);
    localparam logic [US_WIDTH-1:0]   US_PER_TICK_RESET = US_WIDTH'(26041);

    // lead math runs two bits wider than the stored value, then saturates
    localparam int LEAD_EXT = LEAD_WIDTH + 2;
    localparam logic signed [LEAD_EXT-1:0] LEAD_MAX = LEAD_EXT'((1 << (LEAD_WIDTH-1)) - 1);
    localparam logic signed [LEAD_EXT-1:0] LEAD_MIN = -LEAD_EXT'(1 << (LEAD_WIDTH-1));
    localparam logic signed [LEAD_EXT-1:0] LEAD_STEP = LEAD_EXT'(TASK_INTERVAL_US);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_US_PER_TICK  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLOCK_DIVIDE = CFG_IDX_WIDTH'(1);

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_MS_TICK      = 3'd0,
        FUNC_TIMING_CLOCK = 3'd1,
        FUNC_START        = 3'd2,
        FUNC_STOP         = 3'd3,
        FUNC_CONTINUE     = 3'd4,
        FUNC_SONG_POS     = 3'd5,
        FUNC_UNGATE       = 3'd6
    } func_t;

    typedef struct packed {
        logic                 seq_tick;
        logic                 clock_out_pulse;
        logic                 clock_fail;
        logic                 seq_start;
        logic                 seq_stop;
        logic                 seq_continue;
        logic                 divider_reset;
        logic                 internal_mode;
        logic [POS_WIDTH-1:0] tick_position;
    } mcf_result_t;

    function automatic logic signed [LEAD_WIDTH-1:0] sat_lead(
        input logic signed [LEAD_EXT-1:0] v
    );
        logic signed [LEAD_EXT-1:0] c;
        begin
            c = v;
            if (v > LEAD_MAX) c = LEAD_MAX;
            if (v < LEAD_MIN) c = LEAD_MIN;
            return c[LEAD_WIDTH-1:0];
        end
    endfunction

endpackage

>>> sv/mcf_core.sv
// ----------------------------------------------------------------------------
// mcf_core: clock follower state and per-event update
// Holds position, transport, watchdog, divider and tempo lead; one event per step.
// ----------------------------------------------------------------------------
module mcf_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [mcf_pkg::FUNC_WIDTH-1:0] func,
    input  logic [mcf_pkg::SPOS_WIDTH-1:0] song_pos,
    input  logic [mcf_pkg::US_WIDTH-1:0]   us_per_tick,
    input  logic [mcf_pkg::DIV_WIDTH-1:0]  clock_divide,
    output mcf_pkg::mcf_result_t          result
);
    import mcf_pkg::*;

    logic [POS_WIDTH-1:0]         tick_pos_reg, tick_pos_next;
    logic                         running_reg, running_next;
    logic [WDOG_WIDTH-1:0]        watchdog_reg, watchdog_next;
    logic                         use_internal_reg, use_internal_next;
    logic [DIV_WIDTH-1:0]         divide_count_reg, divide_count_next;
    logic signed [LEAD_WIDTH-1:0] time_lead_reg, time_lead_next;

    logic [POS_WIDTH-1:0]         pos_adv;
    logic [DIV_WIDTH:0]           div_inc;
    logic signed [LEAD_WIDTH-1:0] lead_up;
    logic signed [LEAD_WIDTH-1:0] lead_dn;
    logic                         pulse_slot;

    assign pos_adv = (tick_pos_reg >= POS_LAST) ? '0 : tick_pos_reg + POS_WIDTH'(1);
    assign div_inc = {1'b0, divide_count_reg} + (DIV_WIDTH+1)'(1);
    assign lead_up = sat_lead(LEAD_EXT'(time_lead_reg) + LEAD_STEP);
    assign lead_dn = sat_lead(LEAD_EXT'(lead_up) - LEAD_EXT'({1'b0, us_per_tick}));
    assign pulse_slot = (tick_pos_reg == POS_WIDTH'(0)) || (tick_pos_reg == POS_WIDTH'(6))
                     || (tick_pos_reg == POS_WIDTH'(12)) || (tick_pos_reg == POS_WIDTH'(18));

    always_comb begin
        tick_pos_next     = tick_pos_reg;
        running_next      = running_reg;
        watchdog_next     = watchdog_reg;
        use_internal_next = use_internal_reg;
        divide_count_next = divide_count_reg;
        time_lead_next    = time_lead_reg;
        result            = '0;

        case (func_t'(func))
            FUNC_MS_TICK: begin
                if (watchdog_reg != '0) begin
                    use_internal_next = 1'b0;
                    watchdog_next     = watchdog_reg - WDOG_WIDTH'(1);
                    if (watchdog_reg == WDOG_WIDTH'(1)) begin
                        result.clock_fail = 1'b1;
                        use_internal_next = 1'b1;
                    end
                end
                if (use_internal_next) begin
                    time_lead_next = lead_up;
                    if (lead_up > 0) begin
                        result.seq_tick = 1'b1;
                        tick_pos_next   = pos_adv;
                        time_lead_next  = lead_dn;
                    end
                end
            end
            FUNC_TIMING_CLOCK: begin
                watchdog_next = WDOG_RELOAD;
                if (running_reg) begin
                    if (divide_count_reg == '0) begin
                        result.clock_out_pulse = pulse_slot;
                        result.seq_tick        = 1'b1;
                        tick_pos_next          = pos_adv;
                    end
                    if (div_inc > {1'b0, clock_divide}) begin
                        divide_count_next = '0;
                    end else begin
                        divide_count_next = div_inc[DIV_WIDTH-1:0];
                    end
                end
            end
            FUNC_START: begin
                watchdog_next        = WDOG_RELOAD;
                tick_pos_next        = '0;
                divide_count_next    = '0;
                running_next         = 1'b1;
                result.divider_reset = 1'b1;
                result.seq_start     = 1'b1;
            end
            FUNC_STOP: begin
                watchdog_next   = WDOG_RELOAD;
                running_next    = 1'b0;
                result.seq_stop = 1'b1;
            end
            FUNC_SONG_POS: begin
                // (pos * 6) mod 24 only depends on the low two bits
                tick_pos_next     = POS_WIDTH'(song_pos[1:0]) * POS_WIDTH'(6);
                divide_count_next = '0;
            end
            FUNC_CONTINUE: begin
                watchdog_next       = WDOG_RELOAD;
                running_next        = 1'b1;
                result.seq_continue = 1'b1;
            end
            FUNC_UNGATE: begin
                if (!use_internal_reg) begin
                    watchdog_next       = WDOG_RELOAD;
                    running_next        = 1'b1;
                    result.seq_continue = 1'b1;
                end
            end
            default: begin
            end
        endcase

        result.internal_mode = use_internal_next;
        result.tick_position = tick_pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_pos_reg     <= '0;
            running_reg      <= 1'b1;
            watchdog_reg     <= '0;
            use_internal_reg <= 1'b1;
            divide_count_reg <= '0;
            time_lead_reg    <= '0;
        end else if (step) begin
            tick_pos_reg     <= tick_pos_next;
            running_reg      <= running_next;
            watchdog_reg     <= watchdog_next;
            use_internal_reg <= use_internal_next;
            divide_count_reg <= divide_count_next;
            time_lead_reg    <= time_lead_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_pos_reg <= POS_LAST)
        else $error("tick position out of range");

    // external mode only while the watchdog still runs
    a_ext_needs_wdog: assert property (@(posedge aclk) disable iff (!aresetn)
        !use_internal_reg |-> watchdog_reg != '0)
        else $error("external mode with expired watchdog");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FUNC_START |=> tick_pos_reg == '0 && divide_count_reg == '0)
        else $error("start did not clear position");

    a_clock_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        step && func == FUNC_TIMING_CLOCK |=> watchdog_reg == WDOG_RELOAD)
        else $error("timing clock did not reload watchdog");

endmodule

>>> sv/midi_clock_follower.sv
// ----------------------------------------------------------------------------
// midi_clock_follower: MIDI clock follower, 24 ticks per quarter note
// Follows external MIDI clock with a watchdog, falls back to an internal tempo.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_func, s_song_pos
//  m_       | out       | m_valid / m_ready   | nine result fields
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One event per cycle unless m_ stalls; an accepted request reaches m_ via the
// input register, then the state update into the result register.
// Reset is synchronous, active low; no clearing pass, cfg_ready is always high.
// A stalled m_ side holds the result register; the input register still takes
// one more request, then s_ready drops until m_ drains.
// ----------------------------------------------------------------------------
module midi_clock_follower (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mcf_pkg::FUNC_WIDTH-1:0]    s_func,
    input  logic [mcf_pkg::SPOS_WIDTH-1:0]    s_song_pos,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_seq_tick,
    output logic                              m_clock_out_pulse,
    output logic                              m_clock_fail,
    output logic                              m_seq_start,
    output logic                              m_seq_stop,
    output logic                              m_seq_continue,
    output logic                              m_divider_reset,
    output logic                              m_internal_mode,
    output logic [mcf_pkg::POS_WIDTH-1:0]     m_tick_position,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcf_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [mcf_pkg::US_WIDTH-1:0]      cfg_data
);
    import mcf_pkg::*;

    logic                  in_vld_reg;
    logic [FUNC_WIDTH-1:0] func_reg;
    logic [SPOS_WIDTH-1:0] spos_reg;
    logic                  out_vld_reg;
    mcf_result_t           out_reg;
    mcf_result_t           result;
    logic                  step;
    logic [US_WIDTH-1:0]   us_per_tick_reg;
    logic [DIV_WIDTH-1:0]  clock_divide_reg;

    assign step      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            us_per_tick_reg  <= US_PER_TICK_RESET;
            clock_divide_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_US_PER_TICK) begin
                us_per_tick_reg <= cfg_data;
            end else if (cfg_index == CFG_CLOCK_DIVIDE) begin
                clock_divide_reg <= cfg_data[DIV_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            spos_reg <= s_song_pos;
        end
    end

    mcf_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .func         (func_reg),
        .song_pos     (spos_reg),
        .us_per_tick  (us_per_tick_reg),
        .clock_divide (clock_divide_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_seq_tick        = out_reg.seq_tick;
    assign m_clock_out_pulse = out_reg.clock_out_pulse;
    assign m_clock_fail      = out_reg.clock_fail;
    assign m_seq_start       = out_reg.seq_start;
    assign m_seq_stop        = out_reg.seq_stop;
    assign m_seq_continue    = out_reg.seq_continue;
    assign m_divider_reset   = out_reg.divider_reset;
    assign m_internal_mode   = out_reg.internal_mode;
    assign m_tick_position   = out_reg.tick_position;

    a_no_step_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready |-> !step)
        else $error("result overwritten while stalled");

    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_vld_reg)
        else $error("result lost after update");

    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !step |=> in_vld_reg && $stable(func_reg) && $stable(spos_reg))
        else $error("pending request dropped");

endmodule
